/* sv/i2cmrt_pkg.sv */
// Shared types, codes and transfer plan lookups for the I2C register-transfer master.
`timescale 1ns / 1ps

package i2cmrt_pkg;

  // Default read burst limit
  localparam int MAX_BURST_DEF = 256;

  // Device address after reset
  localparam logic [6:0] DEV_ADDR_RST = 7'd21;

  // Command codes on the kind field
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_WR   = 2'd1;
  localparam logic [1:0] KIND_RD   = 2'd2;

  // Transfer modes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_WR   = 2'd1;
  localparam logic [1:0] MODE_RD   = 2'd2;

  // Step kinds of a transfer plan
  localparam logic [2:0] STEP_START = 3'd0;
  localparam logic [2:0] STEP_TX    = 3'd1;
  localparam logic [2:0] STEP_RXACK = 3'd2;
  localparam logic [2:0] STEP_RX    = 3'd3;
  localparam logic [2:0] STEP_MACK  = 3'd4;
  localparam logic [2:0] STEP_STOP  = 3'd5;

  // Plan index width (read plan has eleven steps)
  localparam int IDX_W = 4;

  // Address byte masks and receive bit mask
  localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
  localparam logic [7:0] ADDR_RD_FLAG = 8'h01;
  localparam logic [7:0] BIT_MSB      = 8'h80;

  typedef logic [2:0] step_kind_t;

  // One input item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [8:0] read_count;
    logic       sda_in;
  } item_t;

  // One result item
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       ack_bit;
    logic       ack_valid;
    logic       done;
  } res_t;

  // Step kind at a plan index
  function automatic step_kind_t step_kind(input logic [1:0] mode,
                                           input logic [IDX_W-1:0] idx);
    step_kind_t k;
    if (mode == MODE_WR) begin
      unique case (idx) inside
        4'd0:             k = STEP_START;
        4'd1, 4'd3, 4'd5: k = STEP_TX;
        4'd2, 4'd4, 4'd6: k = STEP_RXACK;
        default:          k = STEP_STOP;
      endcase
    end else begin
      unique case (idx) inside
        4'd0, 4'd5:       k = STEP_START;
        4'd1, 4'd3, 4'd6: k = STEP_TX;
        4'd2, 4'd4, 4'd7: k = STEP_RXACK;
        4'd8:             k = STEP_RX;
        4'd9:             k = STEP_MACK;
        default:          k = STEP_STOP;
      endcase
    end
    return k;
  endfunction

  // Byte sent by a transmit step
  function automatic logic [7:0] tx_byte(input logic [1:0] mode,
                                         input logic [IDX_W-1:0] idx,
                                         input logic [6:0] dev_addr,
                                         input logic [7:0] saved_reg,
                                         input logic [7:0] saved_wr);
    logic [7:0] a;
    logic [7:0] b;
    a = {dev_addr, 1'b0} & ADDR_WR_MASK;
    if (idx == 4'd1) begin
      b = a;
    end else if (idx == 4'd3) begin
      b = saved_reg;
    end else if (mode == MODE_WR && idx == 4'd5) begin
      b = saved_wr;
    end else if (mode == MODE_RD && idx == 4'd6) begin
      b = a | ADDR_RD_FLAG;
    end else begin
      b = 8'd0;
    end
    return b;
  endfunction

endpackage

/* sv/i2cmrt_seq.sv */
// Transfer sequencer: plan step, pin phase, bit and byte state, one pin phase per item.
`timescale 1ns / 1ps

module i2cmrt_seq #(
  parameter int MAX_BURST = i2cmrt_pkg::MAX_BURST_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  i2cmrt_pkg::item_t item,
  input  logic [6:0]        device_address,
  output i2cmrt_pkg::res_t  res
);
  import i2cmrt_pkg::*;

  localparam int CNT_W = $clog2(MAX_BURST + 1);

  // Sequencer state
  logic                 busy, busy_next;
  logic [1:0]           mode, mode_next;
  logic [IDX_W-1:0]     idx, idx_next;
  logic [1:0]           phase, phase_next;
  logic [2:0]           bit_pos, bit_pos_next;
  logic [7:0]           shift_byte, shift_byte_next;
  logic [7:0]           saved_register, saved_register_next;
  logic [7:0]           saved_write_byte, saved_write_byte_next;
  logic [CNT_W-1:0]     bytes_remaining, bytes_remaining_next;
  logic                 scl_level, scl_level_next;
  logic                 sda_level, sda_level_next;

  // Working signals
  logic                 cmd;
  logic [8:0]           cnt;
  logic [CNT_W-1:0]     cnt_sat;
  step_kind_t           k;
  step_kind_t           k_enter;
  logic                 fin;
  logic                 hold_phase;
  logic                 ent;
  logic [IDX_W-1:0]     nidx;

  // Command decode and burst length clamp
  assign cmd = !busy && (item.kind == KIND_WR || item.kind == KIND_RD);
  assign cnt = (item.read_count == 9'd0) ? 9'd1 : item.read_count;
  assign cnt_sat = (int'(cnt) > MAX_BURST) ? CNT_W'(MAX_BURST) : CNT_W'(cnt);

  // One pin phase of the current step
  always_comb begin
    busy_next             = busy;
    mode_next             = mode;
    idx_next              = idx;
    phase_next            = phase;
    bit_pos_next          = bit_pos;
    shift_byte_next       = shift_byte;
    saved_register_next   = saved_register;
    saved_write_byte_next = saved_write_byte;
    bytes_remaining_next  = bytes_remaining;
    scl_level_next        = scl_level;
    sda_level_next        = sda_level;
    res                   = '0;
    k                     = STEP_STOP;
    k_enter               = STEP_STOP;
    fin                   = 1'b0;
    hold_phase            = 1'b0;
    ent                   = 1'b0;
    nidx                  = '0;

    // Latch a command and enter the first start step
    if (cmd) begin
      mode_next             = item.kind;
      saved_register_next   = item.reg_addr;
      saved_write_byte_next = item.write_data;
      bytes_remaining_next  = cnt_sat;
      busy_next             = 1'b1;
      idx_next              = '0;
      phase_next            = 2'd0;
      bit_pos_next          = 3'd0;
    end

    if (busy_next) begin
      k = step_kind(mode_next, idx_next);
      unique case (k)
        STEP_START: begin
          case (phase_next)
            2'd0:    sda_level_next = 1'b1;
            2'd1:    scl_level_next = 1'b1;
            2'd2:    sda_level_next = 1'b0;
            default: begin
              scl_level_next = 1'b0;
              fin            = 1'b1;
            end
          endcase
        end
        STEP_TX: begin
          case (phase_next)
            2'd0:    sda_level_next = shift_byte_next[~bit_pos_next];
            2'd1:    scl_level_next = 1'b1;
            default: begin
              scl_level_next = 1'b0;
              if (bit_pos_next == 3'd7) begin
                fin = 1'b1;
              end else begin
                bit_pos_next = bit_pos_next + 3'd1;
                phase_next   = 2'd0;
                hold_phase   = 1'b1;
              end
            end
          endcase
        end
        STEP_RXACK: begin
          case (phase_next)
            2'd0:    sda_level_next = 1'b1;
            2'd1: begin
              scl_level_next = 1'b1;
              res.ack_bit    = item.sda_in;
              res.ack_valid  = 1'b1;
            end
            default: begin
              scl_level_next = 1'b0;
              fin            = 1'b1;
            end
          endcase
        end
        STEP_RX: begin
          case (phase_next)
            2'd0:    sda_level_next = 1'b1;
            2'd1: begin
              scl_level_next = 1'b1;
              if (item.sda_in) begin
                shift_byte_next = shift_byte_next | (BIT_MSB >> bit_pos_next);
              end
              if (bit_pos_next == 3'd7) begin
                res.read_byte  = shift_byte_next;
                res.read_valid = 1'b1;
              end
            end
            default: begin
              scl_level_next = 1'b0;
              if (bit_pos_next == 3'd7) begin
                fin = 1'b1;
              end else begin
                bit_pos_next = bit_pos_next + 3'd1;
                phase_next   = 2'd1;
                hold_phase   = 1'b1;
              end
            end
          endcase
        end
        STEP_MACK: begin
          case (phase_next)
            2'd0:    sda_level_next = (bytes_remaining_next <= CNT_W'(1));
            2'd1:    scl_level_next = 1'b1;
            default: begin
              scl_level_next = 1'b0;
              if (bytes_remaining_next != '0) begin
                bytes_remaining_next = bytes_remaining_next - CNT_W'(1);
              end
              fin = 1'b1;
            end
          endcase
        end
        default: begin
          // stop condition
          case (phase_next)
            2'd0:    sda_level_next = 1'b0;
            2'd1:    scl_level_next = 1'b1;
            default: begin
              sda_level_next = 1'b1;
              fin            = 1'b1;
            end
          endcase
        end
      endcase

      // Step sequencing: next byte, loop back for more reads, or finish
      if (fin) begin
        if (k == STEP_MACK && bytes_remaining_next != '0) begin
          ent  = 1'b1;
          nidx = idx_next - IDX_W'(1);
        end else if (k == STEP_STOP) begin
          busy_next    = 1'b0;
          mode_next    = MODE_NONE;
          phase_next   = 2'd0;
          bit_pos_next = 3'd0;
          res.done     = 1'b1;
        end else begin
          ent  = 1'b1;
          nidx = idx_next + IDX_W'(1);
        end
      end else if (!hold_phase) begin
        phase_next = phase_next + 2'd1;
      end

      // Enter a new step
      if (ent) begin
        k_enter      = step_kind(mode_next, nidx);
        idx_next     = nidx;
        phase_next   = 2'd0;
        bit_pos_next = 3'd0;
        if (k_enter == STEP_TX) begin
          shift_byte_next = tx_byte(mode_next, nidx, device_address,
                                    saved_register_next, saved_write_byte_next);
        end else if (k_enter == STEP_RX) begin
          shift_byte_next = 8'd0;
        end
      end
    end

    res.scl  = scl_level_next;
    res.sda  = sda_level_next;
    res.busy = busy_next;
  end

  // State registers, advanced once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      mode             <= MODE_NONE;
      idx              <= '0;
      phase            <= 2'd0;
      bit_pos          <= 3'd0;
      shift_byte       <= 8'd0;
      saved_register   <= 8'd0;
      saved_write_byte <= 8'd0;
      bytes_remaining  <= '0;
      scl_level        <= 1'b1;
      sda_level        <= 1'b1;
    end else if (en) begin
      busy             <= busy_next;
      mode             <= mode_next;
      idx              <= idx_next;
      phase            <= phase_next;
      bit_pos          <= bit_pos_next;
      shift_byte       <= shift_byte_next;
      saved_register   <= saved_register_next;
      saved_write_byte <= saved_write_byte_next;
      bytes_remaining  <= bytes_remaining_next;
      scl_level        <= scl_level_next;
      sda_level        <= sda_level_next;
    end
  end

  // Only a start step uses the fourth pin phase
  a_phase3_start: assert property (@(posedge clk) disable iff (rst)
    busy && phase == 2'd3 |-> step_kind(mode, idx) == STEP_START)
    else $error("fourth phase outside a start step");

  // Bit position moves only in byte steps
  a_bitpos_byte: assert property (@(posedge clk) disable iff (rst)
    busy && bit_pos != 3'd0 |->
      step_kind(mode, idx) == STEP_TX || step_kind(mode, idx) == STEP_RX)
    else $error("bit position set outside a byte step");

  // A completed stop leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    en && res.done |=> !busy && mode == MODE_NONE)
    else $error("sequencer busy after stop");

  // A received byte and a target acknowledge never share a phase
  a_excl_valid: assert property (@(posedge clk) disable iff (rst)
    en |-> !(res.read_valid && res.ack_valid))
    else $error("read byte and ack reported together");

endmodule

/* sv/i2c_master_register_transfer_top.sv */
// Top level: input register, sequencer, result register and device address register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------------
//   in      | into      | in_valid / in_stall    | kind reg_addr write_data read_count sda_in
//   out     | out of    | out_valid / out_stall  | scl_out sda_out busy_res read_byte
//           |           |                        | read_valid ack_bit ack_valid done_res
//   cfg     | into      | cfg_valid / cfg_ready  | cfg_data (device_address)
//
// One item per cycle sustained while out_stall is low; each item is one pin phase of the bus.
// An item passes through the input register, then the sequencer step into the result register.
// The sequencer state loop (step, phase, bit position) closes through the sequencer state registers.
// Synchronous reset clears the sequencer to idle with both lines released, address 21.
// in_stall rises only when the input register holds an item and the result register is
// full and stalled; cfg_ready is always high.
`timescale 1ns / 1ps

module i2c_master_register_transfer_top #(
  parameter int MAX_BURST = i2cmrt_pkg::MAX_BURST_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // input items
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic [8:0] read_count,
  input  logic       sda_in,
  // result items
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_out,
  output logic       sda_out,
  output logic       busy_res,
  output logic [7:0] read_byte,
  output logic       read_valid,
  output logic       ack_bit,
  output logic       ack_valid,
  output logic       done_res,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);
  import i2cmrt_pkg::*;

  logic       q_valid;
  item_t      q_item;
  item_t      in_item;
  res_t       res;
  res_t       out_res;
  logic       move;
  logic       en;
  logic       accept;
  logic [6:0] device_address;

  // Handshake: result slot frees up, input stage drains into it
  assign move      = !out_valid || !out_stall;
  assign en        = q_valid && move;
  assign in_stall  = q_valid && !move;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign in_item.kind       = kind;
  assign in_item.reg_addr   = reg_addr;
  assign in_item.write_data = write_data;
  assign in_item.read_count = read_count;
  assign in_item.sda_in     = sda_in;

  // Device address register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEV_ADDR_RST;
    end else if (cfg_valid && cfg_ready) begin
      device_address <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (move) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_item <= in_item;
    end
  end

  // Sequencer
  i2cmrt_seq #(
    .MAX_BURST (MAX_BURST)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .item           (q_item),
    .device_address (device_address),
    .res            (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= en;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= res;
    end
  end

  assign scl_out    = out_res.scl;
  assign sda_out    = out_res.sda;
  assign busy_res   = out_res.busy;
  assign read_byte  = out_res.read_byte;
  assign read_valid = out_res.read_valid;
  assign ack_bit    = out_res.ack_bit;
  assign ack_valid  = out_res.ack_valid;
  assign done_res   = out_res.done;

endmodule

/* dv/tb_i2c_master_register_transfer_top.sv */
// Testbench for the I2C register-transfer master: directed items, random transactions, scoreboard.
`timescale 1ns / 1ps

module tb_i2c_master_register_transfer_top;
  import i2cmrt_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int PHASE_ITEMS = 300;
  localparam int NUM_PHASES  = 6;
  localparam int HOLD_CYCLES = 80;
  localparam logic [1:0] KIND_SPARE = 2'd3;  // unused code, behaves as a tick

  typedef struct {
    item_t it;
    bit    typed;
    res_t  want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] kind = KIND_TICK;
  logic [7:0] reg_addr = 8'd0;
  logic [7:0] write_data = 8'd0;
  logic [8:0] read_count = 9'd0;
  logic       sda_in = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       ack_bit;
  logic       ack_valid;
  logic       done_res;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = 7'd0;

  // Bus-level predictor state
  logic [6:0] pr_addr;
  logic [5:0] pr_step;
  logic [1:0] pr_mode;
  logic [2:0] pr_bit;
  logic [7:0] pr_shift;
  logic [7:0] pr_reg;
  logic [7:0] pr_wr;
  logic [8:0] pr_left;
  logic       pr_scl;
  logic       pr_sda;
  int         pr_phase;

  res_t     bus_levels_due[$];
  dir_row_t dir_rows[$];

  // Run controls and tallies
  bit steady_in;
  bit steady_out;
  int holds_asked;
  int holds_served;
  int errors;
  int items_sent;
  int results_seen;
  int bytes_read;
  int acks_seen;
  int transfers_done;
  int in_stall_cycles;
  int forced_count;

  i2c_master_register_transfer_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .reg_addr(reg_addr), .write_data(write_data),
    .read_count(read_count), .sda_in(sda_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .scl_out(scl_out), .sda_out(sda_out), .busy_res(busy_res),
    .read_byte(read_byte), .read_valid(read_valid),
    .ack_bit(ack_bit), .ack_valid(ack_valid), .done_res(done_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Run limit
  initial begin
    #(CLK_PERIOD * 400000);
    $display("status: fail");
    $finish;
  end

  // Step kind at a position of the current transfer
  function automatic logic [2:0] plan_kind(input logic [1:0] m, input logic [3:0] i);
    if (m == MODE_WR) begin
      if (i == 4'd0) return STEP_START;
      if (i >= 4'd7) return STEP_STOP;
      return i[0] ? STEP_TX : STEP_RXACK;
    end
    case (i)
      4'd0, 4'd5:       return STEP_START;
      4'd1, 4'd3, 4'd6: return STEP_TX;
      4'd2, 4'd4, 4'd7: return STEP_RXACK;
      4'd8:             return STEP_RX;
      4'd9:             return STEP_MACK;
      default:          return STEP_STOP;
    endcase
  endfunction

  function automatic int plan_len();
    return (pr_mode == MODE_WR) ? 8 : 11;
  endfunction

  // Byte shifted out by a transmit step
  function automatic logic [7:0] sent_byte(input logic [3:0] i);
    logic [7:0] a;
    a = {pr_addr, 1'b0};
    if (i == 4'd1) return a;
    if (i == 4'd3) return pr_reg;
    if (pr_mode == MODE_WR && i == 4'd5) return pr_wr;
    if (pr_mode == MODE_RD && i == 4'd6) return a | 8'h01;
    return 8'h00;
  endfunction

  function automatic res_t pins(input logic scl, input logic sda, input logic busy);
    res_t r;
    r = '0;
    r.scl = scl;
    r.sda = sda;
    r.busy = busy;
    return r;
  endfunction

  task automatic enter_step(input logic [3:0] i);
    logic [2:0] k;
    k = plan_kind(pr_mode, i);
    pr_step = 6'(i) + 6'd1;
    pr_phase = 0;
    pr_bit = 3'd0;
    if (k == STEP_TX) pr_shift = sent_byte(i);
    else if (k == STEP_RX) pr_shift = 8'h00;
  endtask

  task automatic reset_bus_model();
    pr_addr = DEV_ADDR_RST;
    pr_step = '0;
    pr_mode = MODE_NONE;
    pr_bit = '0;
    pr_shift = '0;
    pr_reg = '0;
    pr_wr = '0;
    pr_left = '0;
    pr_scl = 1'b1;
    pr_sda = 1'b1;
    pr_phase = 0;
  endtask

  // One pin phase of the bus for one accepted item
  task automatic advance_bus(input item_t it, output res_t r);
    logic [2:0] k;
    logic [3:0] idx;
    logic [8:0] cnt;
    bit fin;
    bit bit_loop;
    r = '0;
    fin = 1'b0;
    bit_loop = 1'b0;
    // a command only starts from idle
    if (pr_step == 0 && (it.kind == KIND_WR || it.kind == KIND_RD)) begin
      cnt = (it.read_count == 0) ? 9'd1 : it.read_count;
      if (cnt > MAX_BURST_DEF) cnt = 9'(MAX_BURST_DEF);
      pr_mode = it.kind;
      pr_reg = it.reg_addr;
      pr_wr = it.write_data;
      pr_left = cnt;
      enter_step(4'd0);
    end
    if (pr_step != 0) begin
      idx = 4'(pr_step - 6'd1);
      k = plan_kind(pr_mode, idx);
      case (k)
        STEP_START: begin
          if (pr_phase == 0) pr_sda = 1'b1;
          else if (pr_phase == 1) pr_scl = 1'b1;
          else if (pr_phase == 2) pr_sda = 1'b0;
          else begin
            pr_scl = 1'b0;
            fin = 1'b1;
          end
        end
        STEP_TX: begin
          if (pr_phase == 0) pr_sda = pr_shift[3'd7 - pr_bit];
          else if (pr_phase == 1) pr_scl = 1'b1;
          else begin
            pr_scl = 1'b0;
            if (pr_bit == 3'd7) fin = 1'b1;
            else begin
              pr_bit++;
              pr_phase = 0;
              bit_loop = 1'b1;
            end
          end
        end
        STEP_RXACK: begin
          if (pr_phase == 0) pr_sda = 1'b1;
          else if (pr_phase == 1) begin
            pr_scl = 1'b1;
            r.ack_bit = it.sda_in;
            r.ack_valid = 1'b1;
          end else begin
            pr_scl = 1'b0;
            fin = 1'b1;
          end
        end
        STEP_RX: begin
          if (pr_phase == 0) pr_sda = 1'b1;
          else if (pr_phase == 1) begin
            pr_scl = 1'b1;
            if (it.sda_in) pr_shift[3'd7 - pr_bit] = 1'b1;
            if (pr_bit == 3'd7) begin
              r.read_byte = pr_shift;
              r.read_valid = 1'b1;
            end
          end else begin
            pr_scl = 1'b0;
            if (pr_bit == 3'd7) fin = 1'b1;
            else begin
              pr_bit++;
              pr_phase = 1;
              bit_loop = 1'b1;
            end
          end
        end
        STEP_MACK: begin
          if (pr_phase == 0) pr_sda = (pr_left <= 9'd1);
          else if (pr_phase == 1) pr_scl = 1'b1;
          else begin
            pr_scl = 1'b0;
            if (pr_left != 0) pr_left--;
            fin = 1'b1;
          end
        end
        default: begin
          if (pr_phase == 0) pr_sda = 1'b0;
          else if (pr_phase == 1) pr_scl = 1'b1;
          else begin
            pr_sda = 1'b1;
            fin = 1'b1;
          end
        end
      endcase
      // move on: next phase, next byte of a burst, end, or next step
      if (bit_loop) begin
      end else if (!fin) begin
        pr_phase++;
      end else if (k == STEP_MACK && pr_left != 0) begin
        enter_step(idx - 4'd1);
      end else if (k == STEP_STOP || int'(idx) + 1 >= plan_len()) begin
        pr_step = '0;
        pr_mode = MODE_NONE;
        pr_phase = 0;
        pr_bit = '0;
        r.done = (k == STEP_STOP);
      end else begin
        enter_step(idx + 4'd1);
      end
    end
    r.scl = pr_scl;
    r.sda = pr_sda;
    r.busy = (pr_step != 0);
  endtask

  // Offer one item, hold it until accepted, then predict its result
  task automatic send_item(input item_t it, input bit typed, input res_t want);
    res_t r;
    while (!steady_in && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind;
    reg_addr <= it.reg_addr;
    write_data <= it.write_data;
    read_count <= it.read_count;
    sda_in <= it.sda_in;
    do @(posedge clk); while (in_stall);
    advance_bus(it, r);
    bus_levels_due.push_back(typed ? want : r);
    items_sent++;
  endtask

  // Random item: well-formed commands from idle, ticks while busy, some noise
  task automatic pick_item(output item_t it, input bit allow_cmd);
    int roll;
    it.reg_addr = 8'($urandom_range(255));
    it.write_data = 8'($urandom_range(255));
    it.read_count = 9'($urandom_range(511));
    it.sda_in = 1'($urandom_range(1));
    roll = $urandom_range(99);
    if (pr_step == 0 && allow_cmd && (forced_count >= 0 || roll < 85)) begin
      if (forced_count >= 0) begin
        it.kind = KIND_RD;
        it.read_count = 9'(forced_count);
        forced_count = -1;
      end else begin
        it.kind = ($urandom_range(99) < 60) ? KIND_RD : KIND_WR;
        roll = $urandom_range(99);
        if (roll < 10) it.read_count = 9'd0;
        else if (roll < 85) it.read_count = 9'($urandom_range(4, 1));
        else it.read_count = 9'($urandom_range(12, 5));
      end
    end else if (pr_step != 0) begin
      if (roll < 90) it.kind = KIND_TICK;
      else if (roll < 95) it.kind = KIND_SPARE;
      else if (roll < 98) it.kind = KIND_RD;
      else it.kind = KIND_WR;
    end else begin
      it.kind = (roll < 50) ? KIND_TICK : KIND_SPARE;
    end
  endtask

  task automatic write_address(input logic [6:0] a);
    cfg_valid <= 1'b1;
    cfg_data <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pr_addr = a;
  endtask

  task automatic add_row(input logic [1:0] k, input logic [7:0] ra, input logic [7:0] wd,
                         input logic [8:0] rc, input logic sd, input bit typed,
                         input res_t want);
    dir_row_t row;
    row.it = '{kind: k, reg_addr: ra, write_data: wd, read_count: rc, sda_in: sd};
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Result side: random stall, long hold-off on request, scoreboard
  always @(posedge clk) begin : result_side
    res_t got;
    res_t want;
    int hold_left;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (in_stall) in_stall_cycles++;
      if (out_valid && !out_stall) begin
        got = {scl_out, sda_out, busy_res, read_byte, read_valid, ack_bit, ack_valid,
               done_res};
        results_seen++;
        if (got.read_valid) bytes_read++;
        if (got.ack_valid) acks_seen++;
        if (got.done) transfers_done++;
        if (bus_levels_due.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          want = bus_levels_due.pop_front();
          check_field("scl_out", want.scl, got.scl);
          check_field("sda_out", want.sda, got.sda);
          check_field("busy_res", want.busy, got.busy);
          check_field("read_byte", want.read_byte, got.read_byte);
          check_field("read_valid", want.read_valid, got.read_valid);
          check_field("ack_bit", want.ack_bit, got.ack_bit);
          check_field("ack_valid", want.ack_valid, got.ack_valid);
          check_field("done_res", want.done, got.done);
        end
      end
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady_out && ($urandom_range(99) < 19);
      end
    end
  end

  // Stimulus
  initial begin
    item_t it;
    logic [6:0] addr;
    int live;
    reset_bus_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed items; the first transfer runs on the reset address
    add_row(KIND_TICK, 8'h00, 8'h00, 9'h000, 1'b0, 1'b1, pins(1'b1, 1'b1, 1'b0));
    add_row(KIND_SPARE, 8'hFF, 8'hFF, 9'h1FF, 1'b1, 1'b1, pins(1'b1, 1'b1, 1'b0));
    add_row(KIND_WR, 8'h00, 8'hFF, 9'h000, 1'b0, 1'b1, pins(1'b1, 1'b1, 1'b1));
    // commands while busy are dropped, the start condition goes on
    add_row(KIND_RD, 8'hFF, 8'h00, 9'h1FF, 1'b1, 1'b1, pins(1'b1, 1'b1, 1'b1));
    add_row(KIND_WR, 8'hA5, 8'h5A, 9'h100, 1'b0, 1'b1, pins(1'b1, 1'b0, 1'b1));
    add_row(KIND_TICK, 8'h00, 8'h00, 9'h000, 1'b1, 1'b1, pins(1'b0, 1'b0, 1'b1));
    for (int n = 0; n < 18; n++)
      add_row((n % 5 == 4) ? KIND_SPARE : KIND_TICK, 8'(n * 17), 8'(~n), 9'(n),
              1'(n), 1'b0, '0);
    foreach (dir_rows[n]) send_item(dir_rows[n].it, dir_rows[n].typed, dir_rows[n].want);

    // Random phases, each on its own device address
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        in_valid <= 1'b0;
        while (bus_levels_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        case (ph)
          1:       addr = 7'h7F;
          2:       addr = 7'h00;
          5:       addr = 7'h55;
          default: addr = 7'($urandom_range(127));
        endcase
        write_address(addr);
      end
      steady_in = (ph == 2 || ph == 4);
      steady_out = (ph == 2);
      if (ph == 4) holds_asked++;
      if (ph == 1) forced_count = 0;
      else if (ph == 3) forced_count = $urandom_range(16, 13);
      else forced_count = -1;
      live = 0;
      while (live < PHASE_ITEMS || pr_step != 0 || forced_count >= 0) begin
        pick_item(it, live < PHASE_ITEMS || forced_count >= 0);
        if (pr_step != 0 || it.kind == KIND_WR || it.kind == KIND_RD) live++;
        send_item(it, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (bus_levels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d items, %0d results, %0d transfers ended by stop.",
             items_sent, results_seen, transfers_done);
    $display("Saw %0d bytes read, %0d target acks, %0d cycles of input backpressure.",
             bytes_read, acks_seen, in_stall_cycles);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
